### design/crfb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package crfb_pkg;

  localparam int ADDR_W    = 26;
  localparam int DIM_W     = 13;
  localparam int POS_W     = 14;
  localparam int STRIDE_W  = 14;
  localparam int PIX_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int MAX_DIM   = 4096;
  localparam int CLIP_W    = 16;   // signed width for clip arithmetic
  localparam int PROD_W    = DIM_W + STRIDE_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SURFACE_WIDTH  = 3'd0,
    REG_SURFACE_HEIGHT = 3'd1,
    REG_ROW_STRIDE     = 3'd2,
    REG_RECT_LEFT      = 3'd3,
    REG_RECT_TOP       = 3'd4,
    REG_RECT_WIDTH     = 3'd5,
    REG_RECT_HEIGHT    = 3'd6,
    REG_FILL_COLOR     = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_PIXEL = 1'b1
  } op_t;

  typedef struct packed {
    logic [DIM_W-1:0]           surface_width;
    logic [DIM_W-1:0]           surface_height;
    logic [STRIDE_W-1:0]        row_stride;
    logic signed [POS_W-1:0]    rect_left;
    logic signed [POS_W-1:0]    rect_top;
    logic signed [POS_W-1:0]    rect_width;
    logic signed [POS_W-1:0]    rect_height;
    logic [PIX_W-1:0]           fill_color;
  } cfg_t;

  typedef struct packed {
    logic             operation;
    logic [PIX_W-1:0] dest_pixel;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] write_address;
    logic [PIX_W-1:0]  write_pixel;
    logic              write_valid;
    logic [ADDR_W-1:0] next_address;
    logic              last_pixel;
    logic              empty_clip;
  } out_item_t;

  // Classified work handed from the front to the back through the queue.
  typedef struct packed {
    logic             write_valid;
    logic             last_pixel;
    logic             empty_clip;
    logic             has_next;
    logic [DIM_W-1:0] cur_row;
    logic [DIM_W-1:0] cur_col;
    logic [DIM_W-1:0] next_row;
    logic [DIM_W-1:0] next_col;
    logic [PIX_W-1:0] dest_pixel;
  } work_t;

endpackage

`default_nettype wire

### design/crfb_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module crfb_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [crfb_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [crfb_pkg::PIX_W-1:0]     wr_data,
  output crfb_pkg::cfg_t                 cfg
);
  import crfb_pkg::*;

  cfg_t cfg_next;

  always_comb begin
    cfg_next = cfg;
    if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_SURFACE_WIDTH:  cfg_next.surface_width  = wr_data[DIM_W-1:0];
        REG_SURFACE_HEIGHT: cfg_next.surface_height = wr_data[DIM_W-1:0];
        REG_ROW_STRIDE:     cfg_next.row_stride     = wr_data[STRIDE_W-1:0];
        REG_RECT_LEFT:      cfg_next.rect_left      = signed'(wr_data[POS_W-1:0]);
        REG_RECT_TOP:       cfg_next.rect_top       = signed'(wr_data[POS_W-1:0]);
        REG_RECT_WIDTH:     cfg_next.rect_width     = signed'(wr_data[POS_W-1:0]);
        REG_RECT_HEIGHT:    cfg_next.rect_height    = signed'(wr_data[POS_W-1:0]);
        REG_FILL_COLOR:     cfg_next.fill_color     = wr_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

`default_nettype wire

### design/crfb_front.sv
`timescale 1ns / 1ps
`default_nettype none

module crfb_front (
  input  logic               clk,
  input  logic               rst,
  input  crfb_pkg::cfg_t     cfg,
  input  logic               item_valid,
  output logic               item_ready,
  input  crfb_pkg::in_item_t item,
  input  logic               queue_full,
  output logic               push,
  output crfb_pkg::work_t    push_item
);
  import crfb_pkg::*;

  logic [DIM_W-1:0] clip_left, clip_top, clip_cols, clip_rows;
  logic [DIM_W-1:0] col_index, row_index;
  logic             fill_active;

  logic [DIM_W-1:0] clip_left_next, clip_top_next, clip_cols_next, clip_rows_next;
  logic [DIM_W-1:0] col_index_next, row_index_next;
  logic             fill_active_next;

  logic [DIM_W-1:0]        sw, sh;
  logic signed [CLIP_W-1:0] x0, y0, w0, h0, x1, y1, w1, h1, w2, h2;
  logic                    clip_empty;
  logic [DIM_W-1:0]        col_inc, col_step, row_step;
  logic                    col_wrap, walk_done;

  assign item_ready = !queue_full;
  assign push       = item_valid && item_ready;

  // Clip the requested rectangle against the surface.
  always_comb begin
    sw = (cfg.surface_width  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.surface_width;
    sh = (cfg.surface_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.surface_height;
    x0 = CLIP_W'(cfg.rect_left);
    y0 = CLIP_W'(cfg.rect_top);
    w0 = CLIP_W'(cfg.rect_width);
    h0 = CLIP_W'(cfg.rect_height);
    x1 = (x0 < 0) ? '0 : x0;
    w1 = (x0 < 0) ? w0 + x0 : w0;
    y1 = (y0 < 0) ? '0 : y0;
    h1 = (y0 < 0) ? h0 + y0 : h0;
    w2 = (x1 + w1 > signed'(CLIP_W'(sw))) ? signed'(CLIP_W'(sw)) - x1 : w1;
    h2 = (y1 + h1 > signed'(CLIP_W'(sh))) ? signed'(CLIP_W'(sh)) - y1 : h1;
    clip_empty = (w2 <= 0) || (h2 <= 0);
  end

  // Raster step from the current pixel.
  always_comb begin
    col_inc   = col_index + DIM_W'(1);
    col_wrap  = col_inc >= clip_cols;
    col_step  = col_wrap ? '0 : col_inc;
    row_step  = col_wrap ? row_index + DIM_W'(1) : row_index;
    walk_done = row_step >= clip_rows;
  end

  always_comb begin
    clip_left_next   = clip_left;
    clip_top_next    = clip_top;
    clip_cols_next   = clip_cols;
    clip_rows_next   = clip_rows;
    col_index_next   = col_index;
    row_index_next   = row_index;
    fill_active_next = fill_active;
    push_item        = '0;
    push_item.dest_pixel = item.dest_pixel;

    if (push) begin
      if (op_t'(item.operation) == OP_START) begin
        col_index_next = '0;
        row_index_next = '0;
        if (clip_empty) begin
          fill_active_next     = 1'b0;
          clip_left_next       = '0;
          clip_top_next        = '0;
          clip_cols_next       = '0;
          clip_rows_next       = '0;
          push_item.empty_clip = 1'b1;
        end else begin
          fill_active_next   = 1'b1;
          clip_left_next     = x1[DIM_W-1:0];
          clip_top_next      = y1[DIM_W-1:0];
          clip_cols_next     = w2[DIM_W-1:0];
          clip_rows_next     = h2[DIM_W-1:0];
          push_item.has_next = 1'b1;
          push_item.next_row = y1[DIM_W-1:0];
          push_item.next_col = x1[DIM_W-1:0];
        end
      end else if (fill_active) begin
        push_item.write_valid = 1'b1;
        push_item.cur_row     = clip_top + row_index;
        push_item.cur_col     = clip_left + col_index;
        if (walk_done) begin
          fill_active_next     = 1'b0;
          col_index_next       = '0;
          row_index_next       = '0;
          push_item.last_pixel = 1'b1;
        end else begin
          col_index_next     = col_step;
          row_index_next     = row_step;
          push_item.has_next = 1'b1;
          push_item.next_row = clip_top + row_step;
          push_item.next_col = clip_left + col_step;
        end
      end
      // a pixel item while idle goes through as an all-zero result
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_left   <= '0;
      clip_top    <= '0;
      clip_cols   <= '0;
      clip_rows   <= '0;
      col_index   <= '0;
      row_index   <= '0;
      fill_active <= 1'b0;
    end else begin
      clip_left   <= clip_left_next;
      clip_top    <= clip_top_next;
      clip_cols   <= clip_cols_next;
      clip_rows   <= clip_rows_next;
      col_index   <= col_index_next;
      row_index   <= row_index_next;
      fill_active <= fill_active_next;
    end
  end

endmodule

`default_nettype wire

### design/crfb_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module crfb_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  crfb_pkg::work_t push_item,
  output logic            full,
  output logic            pop_valid,
  input  logic            pop,
  output crfb_pkg::work_t pop_item
);
  import crfb_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  work_t            slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;

  assign full      = count == (PTR_W+1)'(DEPTH);
  assign pop_valid = count != '0;
  assign pop_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (PTR_W+1)'(1);
        2'b01:   count <= count - (PTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/crfb_back.sv
`timescale 1ns / 1ps
`default_nettype none

module crfb_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [crfb_pkg::STRIDE_W-1:0] row_stride,
  input  logic [crfb_pkg::PIX_W-1:0]    fill_color,
  input  logic                          work_valid,
  output logic                          work_pop,
  input  crfb_pkg::work_t               work,
  output logic                          result_valid,
  input  logic                          result_ready,
  output crfb_pkg::out_item_t           result
);
  import crfb_pkg::*;

  // rounded divide by 255 of a: floor((z*257) >> 16), z = a + 128
  function automatic logic [7:0] div255(input logic [15:0] z);
    logic [23:0] t;
    t = {8'h00, z} + {z, 8'h00};
    return t[23:16];
  endfunction

  logic              s1_valid;
  logic              s1_write, s1_last, s1_empty, s1_has_next;
  logic [PROD_W-1:0] s1_cur_prod, s1_next_prod;
  logic [DIM_W-1:0]  s1_cur_col, s1_next_col;
  logic [15:0]       s1_sum_r, s1_sum_g, s1_sum_b;

  logic        out_open, s1_open;
  logic [7:0]  alpha, inv_alpha;
  logic [15:0] sum_r, sum_g, sum_b;
  logic [PROD_W-1:0] cur_addr, next_addr;
  out_item_t   result_next;

  assign out_open = !result_valid || result_ready;
  assign s1_open  = !s1_valid || out_open;
  assign work_pop = work_valid && s1_open;

  // Stage 1: row products and channel products.
  always_comb begin
    alpha     = fill_color[31:24];
    inv_alpha = 8'd255 - alpha;
    sum_r = 16'(alpha * fill_color[23:16]) + 16'(inv_alpha * work.dest_pixel[23:16])
          + 16'd128;
    sum_g = 16'(alpha * fill_color[15:8])  + 16'(inv_alpha * work.dest_pixel[15:8])
          + 16'd128;
    sum_b = 16'(alpha * fill_color[7:0])   + 16'(inv_alpha * work.dest_pixel[7:0])
          + 16'd128;
  end

  always_ff @(posedge clk) begin
    if (work_pop) begin
      s1_write     <= work.write_valid;
      s1_last      <= work.last_pixel;
      s1_empty     <= work.empty_clip;
      s1_has_next  <= work.has_next;
      s1_cur_prod  <= work.cur_row * row_stride;
      s1_next_prod <= work.next_row * row_stride;
      s1_cur_col   <= work.cur_col;
      s1_next_col  <= work.next_col;
      s1_sum_r     <= sum_r;
      s1_sum_g     <= sum_g;
      s1_sum_b     <= sum_b;
    end
  end

  // Stage 2: finish addresses and divide, drop unused fields to zero.
  always_comb begin
    cur_addr  = s1_cur_prod  + PROD_W'(s1_cur_col);
    next_addr = s1_next_prod + PROD_W'(s1_next_col);
    result_next = '0;
    result_next.write_valid = s1_write;
    result_next.last_pixel  = s1_last;
    result_next.empty_clip  = s1_empty;
    if (s1_write) begin
      result_next.write_address = cur_addr[ADDR_W-1:0];
      result_next.write_pixel   = {8'hff, div255(s1_sum_r), div255(s1_sum_g),
                                   div255(s1_sum_b)};
    end
    if (s1_has_next) begin
      result_next.next_address = next_addr[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (out_open && s1_valid) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (s1_open) begin
        s1_valid <= work_valid;
      end
      if (out_open) begin
        result_valid <= s1_valid;
      end
    end
  end

endmodule

`default_nettype wire

### design/clipped_rect_fill_blend_top.sv
// Rectangle fill engine with straight-alpha blending.
// Configuration: write surface size, row stride, rectangle and fill color
// through cfg_valid/cfg_index/cfg_data; cfg_ready is always high. Write only
// while no item is in flight.
// Items enter on item_valid/item_ready. A start item clips the rectangle and
// returns the first pixel address in next_address, or empty_clip when the
// clipped area is empty. Each following pixel item carries the destination
// pixel at that address and returns write_address/write_pixel, the address
// to fetch next, and last_pixel on the final write. A pixel item with no
// fill running returns an all-zero result.
// Path: an accepted item is written into a queue slot at the accepting edge,
// then moves through the product stage and the output register.
// Throughput: one item per clock while result_ready stays high, set by the
// front walker and the two-stage back end.
// The front accepts into a two-entry queue, so it keeps taking items while a
// result waits. When result_ready is low the output holds, the back end and
// queue fill, and item_ready drops once the queue is full.
// Reset: synchronous, clears configuration, walker state, queue and pipeline.
`timescale 1ns / 1ps
`default_nettype none

module clipped_rect_fill_blend_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [crfb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [crfb_pkg::PIX_W-1:0]     cfg_data,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  crfb_pkg::in_item_t             item,
  output logic                           result_valid,
  input  logic                           result_ready,
  output crfb_pkg::out_item_t            result
);
  import crfb_pkg::*;

  cfg_t  cfg;
  logic  queue_full, push, work_valid, work_pop;
  work_t push_item, work;

  // Register writes go straight into the configuration register; never stall them.
  assign cfg_ready = 1'b1;

  crfb_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Front: clip on start, walk the raster, classify each item.
  crfb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  // Decouple the walker from the blend/address pipeline.
  crfb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop_valid (work_valid),
    .pop       (work_pop),
    .pop_item  (work)
  );

  // Back: address multiply and per-channel blend, then output register.
  crfb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .row_stride   (cfg.row_stride),
    .fill_color   (cfg.fill_color),
    .work_valid   (work_valid),
    .work_pop     (work_pop),
    .work         (work),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire
